// ----- design/l1nkd_pkg.sv -----
package l1nkd_pkg;

   localparam int LANES        = 4;
   localparam int ELEMENT_BITS = 16;
   localparam int LANE_CNT_W   = 3;
   localparam int DIST_W       = 32;
   localparam int SUM_W        = 48;
   localparam int CNT_W        = 16;

   localparam int LANE_SUM_W = ELEMENT_BITS + $clog2(LANES);
   localparam int ADD_W      = ((LANE_SUM_W > DIST_W) ? LANE_SUM_W : DIST_W) + 1;
   localparam int LANE_CMP_W = ((LANE_CNT_W > $clog2(LANES) + 1) ? LANE_CNT_W
                                                                  : $clog2(LANES) + 1);
   localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
   localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

   typedef logic signed [ELEMENT_BITS-1:0] elem_type;
   typedef logic [ELEMENT_BITS-1:0]        diff_type;
   typedef logic [DIST_W-1:0]              dist_type;

   typedef struct packed {
      logic eov;
      logic eor;
      logic eoq;
   } mark_type;

endpackage

// ----- design/l1nkd_lane.sv -----
module l1nkd_lane import l1nkd_pkg::*; (
   input  logic     clock,
   input  logic     advance,
   input  logic     lane_en,
   input  elem_type query_elem,
   input  elem_type ref_elem,
   output diff_type diff_ff
);

   logic [ELEMENT_BITS:0] delta;
   logic [ELEMENT_BITS:0] mag;
   diff_type              diff_in;

   assign delta   = {query_elem[ELEMENT_BITS-1], query_elem}
                  - {ref_elem[ELEMENT_BITS-1], ref_elem};
   assign mag     = delta[ELEMENT_BITS] ? (~delta + 1'b1) : delta;
   assign diff_in = lane_en ? mag[ELEMENT_BITS-1:0] : '0;

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff <= diff_in;
      end
   end

endmodule

// ----- design/l1nkd_merge.sv -----
module l1nkd_merge import l1nkd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     s1_valid,
   input  mark_type s1_mark,
   input  diff_type diffs [LANES],
   output logic     s2_valid_ff,
   output mark_type s2_mark_ff,
   output dist_type dist_ff
);

   dist_type              acc_ff;
   dist_type              acc_in;
   dist_type              acc_new;
   logic [LANE_SUM_W-1:0] lane_sum;
   logic [ADD_W-1:0]      total;

   always_comb begin
      lane_sum = '0;
      for (int i = 0; i < LANES; i++) begin
         lane_sum = lane_sum + LANE_SUM_W'(diffs[i]);
      end
   end

   assign total   = ADD_W'(acc_ff) + ADD_W'(lane_sum);
   assign acc_new = (total > ADD_W'(DIST_MAX)) ? DIST_MAX : total[DIST_W-1:0];

   always_comb begin
      acc_in = acc_ff;
      if (s1_valid) begin
         acc_in = s1_mark.eov ? '0 : acc_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         acc_ff      <= acc_in;
         s2_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dist_ff    <= acc_new;
         s2_mark_ff <= s1_mark;
      end
   end

endmodule

// ----- design/l1nkd_div.sv -----
module l1nkd_div import l1nkd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             busy_ff,
   output logic             done_ff,
   output dist_type         average
);

   logic [SUM_W-1:0]     quo_ff;
   logic [CNT_W-1:0]     rem_ff;
   logic [CNT_W-1:0]     div_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [CNT_W:0]       shifted;
   logic                 fits;

   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign fits    = shifted >= {1'b0, div_ff};
   assign average = (|quo_ff[SUM_W-1:DIST_W]) ? DIST_MAX : quo_ff[DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(SUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[SUM_W-2:0], fits};
         rem_ff <= fits ? CNT_W'(shifted - {1'b0, div_ff}) : shifted[CNT_W-1:0];
      end
   end

endmodule

// ----- design/l1_nearest_keyframe_distance.sv -----
// A frame result passes the lane registers, the merge stage and the result register
// after the transfer that ends the frame; a final result also passes the divider.
// Throughput: one item per cycle; a frame result held by the receiver stalls input,
// and the bit-serial 48-step divider for the set average holds off new items from
// when the set's last transfer leaves the merge stage until its done strobe has ended.
// Reset is synchronous, active high, and clears all accumulators and valids.
module l1_nearest_keyframe_distance import l1nkd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  elem_type              req_query_elem_0,
   input  elem_type              req_query_elem_1,
   input  elem_type              req_query_elem_2,
   input  elem_type              req_query_elem_3,
   input  elem_type              req_ref_elem_0,
   input  elem_type              req_ref_elem_1,
   input  elem_type              req_ref_elem_2,
   input  elem_type              req_ref_elem_3,
   input  logic [LANE_CNT_W-1:0] req_lanes_used,
   input  logic                  req_end_of_vector,
   input  logic                  req_end_of_reference,
   input  logic                  req_end_of_query,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dist_type              rsp_frame_min_distance,
   output dist_type              rsp_average_distance,
   output logic                  rsp_final_res
);

   elem_type         q_lane [LANES];
   elem_type         r_lane [LANES];
   diff_type         diffs  [LANES];
   logic [LANES-1:0] lane_en;

   mark_type         req_mark;
   logic             advance;
   logic             out_free;
   logic             s1_valid_ff;
   mark_type         s1_mark_ff;
   logic             s2_valid;
   mark_type         s2_mark;
   dist_type         s2_dist;

   dist_type         frame_min_ff;
   logic             seen_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0] count_ff;
   dist_type         min_new;
   logic [SUM_W:0]   sum_total;
   logic [SUM_W-1:0] sum_new;
   logic [CNT_W-1:0] count_new;
   logic             take;
   logic             div_start;
   logic             div_busy;
   logic             div_done;
   dist_type         div_average;

   logic             rsp_valid_ff;
   dist_type         rsp_min_ff;
   dist_type         rsp_avg_ff;
   logic             rsp_final_ff;

   assign q_lane[0] = req_query_elem_0;
   assign q_lane[1] = req_query_elem_1;
   assign q_lane[2] = req_query_elem_2;
   assign q_lane[3] = req_query_elem_3;
   assign r_lane[0] = req_ref_elem_0;
   assign r_lane[1] = req_ref_elem_1;
   assign r_lane[2] = req_ref_elem_2;
   assign r_lane[3] = req_ref_elem_3;

   assign req_mark.eoq = req_end_of_query;
   assign req_mark.eor = req_end_of_query | req_end_of_reference;
   assign req_mark.eov = req_end_of_query | req_end_of_reference | req_end_of_vector;

   // stall the whole pipe while the divider runs or a frame end meets a blocked slot
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = !div_busy && !div_done && !(s2_valid && s2_mark.eor && !out_free);
   assign req_ready = advance;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      assign lane_en[g] = LANE_CMP_W'(req_lanes_used) > LANE_CMP_W'(g);

      l1nkd_lane u_lane (
         .clock      (clock),
         .advance    (advance),
         .lane_en    (lane_en[g]),
         .query_elem (q_lane[g]),
         .ref_elem   (r_lane[g]),
         .diff_ff    (diffs[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mark_ff <= req_mark;
      end
   end

   l1nkd_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .s1_valid    (s1_valid_ff),
      .s1_mark     (s1_mark_ff),
      .diffs       (diffs),
      .s2_valid_ff (s2_valid),
      .s2_mark_ff  (s2_mark),
      .dist_ff     (s2_dist)
   );

   assign take      = advance && s2_valid;
   assign min_new   = (!seen_ff || s2_dist < frame_min_ff) ? s2_dist : frame_min_ff;
   assign sum_total = {1'b0, sum_ff} + (SUM_W + 1)'(min_new);
   assign sum_new   = sum_total[SUM_W] ? SUM_MAX : sum_total[SUM_W-1:0];
   assign count_new = (count_ff == CNT_MAX) ? count_ff : count_ff + 1'b1;
   assign div_start = take && s2_mark.eoq;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_min_ff <= '0;
         seen_ff      <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
      end else if (take && s2_mark.eor) begin
         frame_min_ff <= '0;
         seen_ff      <= 1'b0;
         sum_ff       <= s2_mark.eoq ? '0 : sum_new;
         count_ff     <= s2_mark.eoq ? '0 : count_new;
      end else if (take && s2_mark.eov) begin
         frame_min_ff <= min_new;
         seen_ff      <= 1'b1;
      end
   end

   l1nkd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (count_new),
      .busy_ff  (div_busy),
      .done_ff  (div_done),
      .average  (div_average)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_done || (take && s2_mark.eor && !s2_mark.eoq)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && s2_mark.eor) begin
         rsp_min_ff   <= min_new;
         rsp_avg_ff   <= '0;
         rsp_final_ff <= 1'b0;
      end else if (div_done) begin
         rsp_avg_ff   <= div_average;
         rsp_final_ff <= 1'b1;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_frame_min_distance = rsp_min_ff;
   assign rsp_average_distance   = rsp_avg_ff;
   assign rsp_final_res          = rsp_final_ff;

`ifndef SYNTHESIS
   a_div_blocks_input: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> !req_ready)
      else $error("input taken while divider busy");

   a_slot_free_at_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> !rsp_valid_ff)
      else $error("divider finished into an occupied result slot");

   a_set_end_clears: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (sum_ff == '0) && (count_ff == '0) && div_busy && !rsp_valid_ff)
      else $error("set end did not clear totals and start divider");

   a_partial_avg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_res |-> rsp_average_distance == '0)
      else $error("non-final result carries an average");
`endif

endmodule

// ----- tb/l1_nearest_keyframe_distance_tb.sv -----
module l1_nearest_keyframe_distance_tb;
   import l1nkd_pkg::*;

   typedef struct packed {
      elem_type [LANES-1:0]  q;
      elem_type [LANES-1:0]  r;
      logic [LANE_CNT_W-1:0] lanes;
      logic                  eov;
      logic                  eor;
      logic                  eoq;
   } feat_chunk_type;

   typedef struct packed {
      dist_type min_dist;
      dist_type avg_dist;
      logic     set_end;
   } frame_result_type;

   logic                  clock;
   logic                  reset                = 1'b1;
   logic                  req_valid            = 1'b0;
   logic                  req_ready;
   elem_type              req_query_elem_0     = '0;
   elem_type              req_query_elem_1     = '0;
   elem_type              req_query_elem_2     = '0;
   elem_type              req_query_elem_3     = '0;
   elem_type              req_ref_elem_0       = '0;
   elem_type              req_ref_elem_1       = '0;
   elem_type              req_ref_elem_2       = '0;
   elem_type              req_ref_elem_3       = '0;
   logic [LANE_CNT_W-1:0] req_lanes_used       = '0;
   logic                  req_end_of_vector    = 1'b0;
   logic                  req_end_of_reference = 1'b0;
   logic                  req_end_of_query     = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready            = 1'b0;
   dist_type              rsp_frame_min_distance;
   dist_type              rsp_average_distance;
   logic                  rsp_final_res;

   // predictor state
   longint unsigned  vec_dist      = 0;
   longint unsigned  frame_best    = 0;
   bit               best_valid    = 1'b0;
   longint unsigned  minima_sum    = 0;
   int unsigned      frames_in_set = 0;
   frame_result_type expected_minima[$];
   frame_result_type oldest_result;

   int idle_pct      = 28;
   int hold_request  = 0;
   int stall_left    = 0;
   int mismatches    = 0;
   int transfers_in  = 0;
   int results_seen  = 0;
   int sets_done     = 0;

   l1_nearest_keyframe_distance uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_query_elem_0       (req_query_elem_0),
      .req_query_elem_1       (req_query_elem_1),
      .req_query_elem_2       (req_query_elem_2),
      .req_query_elem_3       (req_query_elem_3),
      .req_ref_elem_0         (req_ref_elem_0),
      .req_ref_elem_1         (req_ref_elem_1),
      .req_ref_elem_2         (req_ref_elem_2),
      .req_ref_elem_3         (req_ref_elem_3),
      .req_lanes_used         (req_lanes_used),
      .req_end_of_vector      (req_end_of_vector),
      .req_end_of_reference   (req_end_of_reference),
      .req_end_of_query       (req_end_of_query),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_frame_min_distance (rsp_frame_min_distance),
      .rsp_average_distance   (rsp_average_distance),
      .rsp_final_res          (rsp_final_res)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("%0t: timeout, %0d results outstanding", $time, expected_minima.size());
      $display("l1_nearest_keyframe_distance test failed");
      $finish;
   end

   task automatic fold_chunk(input feat_chunk_type c);
      longint unsigned  acc, gap, mean;
      longint           qv, rv;
      int               n;
      bit               eov, eor, eoq;
      frame_result_type res;
      n   = (c.lanes > LANES) ? LANES : c.lanes;
      eoq = c.eoq;
      eor = eoq | c.eor;
      eov = eor | c.eov;
      acc = vec_dist;
      for (int i = 0; i < n; i++) begin
         qv  = $signed(c.q[i]);
         rv  = $signed(c.r[i]);
         gap = (qv > rv) ? qv - rv : rv - qv;
         acc += gap;
         if (acc > DIST_MAX) acc = DIST_MAX;
      end
      vec_dist = acc;
      if (eov) begin
         if (!best_valid || vec_dist < frame_best) frame_best = vec_dist;
         best_valid = 1'b1;
         vec_dist   = 0;
         if (eor) begin
            minima_sum += frame_best;
            if (minima_sum > SUM_MAX) minima_sum = SUM_MAX;
            if (frames_in_set < CNT_MAX) frames_in_set++;
            res.min_dist = dist_type'(frame_best);
            res.avg_dist = '0;
            res.set_end  = 1'b0;
            if (eoq) begin
               mean = minima_sum / frames_in_set;
               if (mean > DIST_MAX) mean = DIST_MAX;
               res.avg_dist  = dist_type'(mean);
               res.set_end   = 1'b1;
               minima_sum    = 0;
               frames_in_set = 0;
               sets_done++;
            end
            expected_minima = {expected_minima, res};
            frame_best = 0;
            best_valid = 1'b0;
         end
      end
   endtask

   function automatic void report_mismatch(string what, longint unsigned want,
                                           longint unsigned got);
      mismatches++;
      if (mismatches <= 20)
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
   endfunction

   // receiver: random idling, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_request > 0) begin
         stall_left   = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_minima.size() == 0) begin
            report_mismatch("unexpected result, frame min", 0, rsp_frame_min_distance);
         end else begin
            oldest_result = expected_minima.pop_front();
            if (rsp_frame_min_distance !== oldest_result.min_dist)
               report_mismatch("frame min", oldest_result.min_dist, rsp_frame_min_distance);
            if (rsp_average_distance !== oldest_result.avg_dist)
               report_mismatch("average", oldest_result.avg_dist, rsp_average_distance);
            if (rsp_final_res !== oldest_result.set_end)
               report_mismatch("final flag", oldest_result.set_end, rsp_final_res);
         end
      end
   end

   task automatic send_chunk(input feat_chunk_type c);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid            <= 1'b1;
      req_query_elem_0     <= c.q[0];
      req_query_elem_1     <= c.q[1];
      req_query_elem_2     <= c.q[2];
      req_query_elem_3     <= c.q[3];
      req_ref_elem_0       <= c.r[0];
      req_ref_elem_1       <= c.r[1];
      req_ref_elem_2       <= c.r[2];
      req_ref_elem_3       <= c.r[3];
      req_lanes_used       <= c.lanes;
      req_end_of_vector    <= c.eov;
      req_end_of_reference <= c.eor;
      req_end_of_query     <= c.eoq;
      do @(posedge clock); while (!req_ready);
      fold_chunk(c);
      transfers_in++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_minima.size() != 0);
   endtask

   function automatic feat_chunk_type flat_chunk(int qv, int rv, int lanes,
                                                 bit eov, bit eor, bit eoq);
      feat_chunk_type c;
      for (int i = 0; i < LANES; i++) begin
         c.q[i] = elem_type'(qv);
         c.r[i] = elem_type'(rv);
      end
      c.lanes = LANE_CNT_W'(lanes);
      c.eov   = eov;
      c.eor   = eor;
      c.eoq   = eoq;
      return c;
   endfunction

   function automatic elem_type rand_elem(int style);
      case (style)
         0: return elem_type'($urandom());
         1: return elem_type'(int'($urandom_range(600)) - 300);
         default: begin
            case ($urandom_range(3))
               0: return elem_type'(16'sh7FFF);
               1: return elem_type'(16'sh8000);
               2: return elem_type'(0);
               default: return elem_type'(-1);
            endcase
         end
      endcase
   endfunction

   function automatic feat_chunk_type rand_chunk(int lanes, bit eov, bit eor, bit eoq,
                                                 int style);
      feat_chunk_type c;
      for (int i = 0; i < LANES; i++) begin
         c.q[i] = rand_elem(style);
         c.r[i] = rand_elem(style);
      end
      c.lanes = LANE_CNT_W'(lanes);
      c.eov   = eov;
      c.eor   = eor;
      c.eoq   = eoq;
      return c;
   endfunction

   // mostly full or partial lane groups, now and then zero or over-range
   function automatic int pick_lanes();
      int k;
      if ($urandom_range(9) < 8) return $urandom_range(4, 1);
      k = $urandom_range(3);
      return (k == 0) ? 0 : 4 + k;
   endfunction

   // well-formed query set; implied flag bits are randomly left clear
   task automatic send_set(int frames, int style);
      int refs, chunks;
      bit eov, eor, eoq;
      for (int f = 0; f < frames; f++) begin
         refs = $urandom_range(4, 1);
         for (int v = 0; v < refs; v++) begin
            chunks = $urandom_range(3, 1);
            for (int k = 0; k < chunks; k++) begin
               eov = (k == chunks - 1);
               eor = eov && (v == refs - 1);
               eoq = eor && (f == frames - 1);
               send_chunk(rand_chunk(pick_lanes(),
                                     eor ? bit'($urandom_range(1)) : eov,
                                     eoq ? bit'($urandom_range(1)) : eor,
                                     eoq, style));
            end
         end
      end
   endtask

   task automatic test_directed();
      idle_pct = 28;
      send_chunk(flat_chunk(32767, -32768, 4, 1, 1, 0));
      send_chunk(flat_chunk(-32768, 32767, 7, 1, 1, 0));
      send_chunk(flat_chunk(-1, -1, 4, 1, 0, 0));
      send_chunk(flat_chunk(0, 5, 3, 1, 1, 0));
      send_chunk(flat_chunk(32767, -32768, 0, 1, 1, 0));
      send_chunk(flat_chunk(1, 0, 5, 0, 0, 0));
      send_chunk(flat_chunk(0, 2, 6, 0, 0, 0));
      send_chunk(flat_chunk(3, 0, 1, 0, 0, 0));
      send_chunk(flat_chunk(-7, 7, 2, 0, 1, 0));
      send_chunk(flat_chunk(2, 0, 1, 1, 0, 0));
      send_chunk(flat_chunk(10, 0, 1, 1, 1, 0));
      send_chunk(flat_chunk(9, 0, 1, 1, 0, 0));
      send_chunk(flat_chunk(1, 0, 1, 0, 1, 0));
      send_chunk(flat_chunk(100, -100, 4, 0, 0, 1));
      send_chunk(flat_chunk(3, 0, 1, 1, 1, 0));
      send_chunk(flat_chunk(0, 4, 1, 1, 1, 1));
      send_chunk(flat_chunk(-32768, -32768, 4, 0, 0, 1));
      for (int n = 0; n < 4; n++)
         send_chunk(rand_chunk($urandom_range(7), 1'b1, 1'b1, n == 3, 0));
      drain_results();
   endtask

   task automatic test_random_sets(int target, int pct);
      int stop_at;
      stop_at  = transfers_in + target;
      idle_pct = pct;
      while (transfers_in < stop_at) begin
         if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(3, 1))
               send_chunk(rand_chunk($urandom_range(7), $urandom_range(3) == 0,
                                     $urandom_range(5) == 0, $urandom_range(15) == 0,
                                     $urandom_range(2)));
         end else begin
            send_set($urandom_range(5, 1), $urandom_range(2));
         end
         if ($urandom_range(99) < 5) drain_results();
      end
      drain_results();
   endtask

   task automatic test_steady_stream();
      test_random_sets(200, 0);
      idle_pct = 28;
   endtask

   task automatic test_result_backpressure();
      idle_pct     = 28;
      hold_request = 400;
      for (int n = 0; n < 150; n++)
         send_chunk(rand_chunk(pick_lanes(), 1'b1, 1'b1, n % 40 == 39, 1));
      drain_results();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_sets(530, 28);
      test_steady_stream();
      test_result_backpressure();
      drain_results();
      repeat (60) @(posedge clock);
      $display("covered %0d input transfers and %0d checked results over %0d query sets,",
               transfers_in, results_seen, sets_done);
      $display("including lane clamping, implied flags, extreme elements, result stalls");
      if (mismatches == 0 && expected_minima.size() == 0) begin
         $display("l1_nearest_keyframe_distance test passed");
      end else begin
         $display("l1_nearest_keyframe_distance test failed");
      end
      $finish;
   end

endmodule
